/* hdl/mandelbrot_escape_time_defines.svh */
// Assertion macros for the Mandelbrot escape-time block.
// Used by the top level; no other dependencies.
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`ifndef SYNTH
`define MET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MET_ASSERT(lbl, prop, msg)
`define MET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/met_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time block.
// No dependencies.
`timescale 1ns / 1ps

package met_pkg;

    localparam int PIXEL_W     = 32;
    localparam int WIDTH_W     = 16;
    localparam int STEP_W      = 31;
    localparam int LIMIT_W     = 16;
    localparam int VALUE_W     = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int SP_W        = WIDTH_W + STEP_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_X_STEP         = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_Y_STEP         = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITERATIONS = 4'd3;

    localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH    = 16'd1024;
    localparam logic [STEP_W-1:0]  RST_X_STEP         = 31'd1048576;
    localparam logic [STEP_W-1:0]  RST_Y_STEP         = 31'd1048576;
    localparam logic [LIMIT_W-1:0] RST_MAX_ITERATIONS = 16'd1000;

    localparam logic [WIDTH_W-1:0] ROW_MAX = 16'hFFFF;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DIV    = 10'b0000000010,
        S_MAP_X  = 10'b0000000100,
        S_MAP_Y  = 10'b0000001000,
        S_MAP_C  = 10'b0000010000,
        S_MUL_XY = 10'b0000100000,
        S_MUL_XX = 10'b0001000000,
        S_MUL_YY = 10'b0010000000,
        S_SQ_Y   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hdl/met_div.sv */
// Restoring divider: one quotient bit per cycle, 16-bit divisor.
// Depends on met_pkg.
`timescale 1ns / 1ps

module met_div #(
    parameter int DW = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DW-1:0]                 dividend,
    input  logic [met_pkg::WIDTH_W-1:0]   divisor,
    output met_pkg::div_status_t          status,
    output logic [DW-1:0]                 quotient,
    output logic [met_pkg::WIDTH_W-1:0]   remainder
);

    localparam int RW = met_pkg::WIDTH_W;
    localparam int CW = $clog2(DW + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW:0]   shifted;
    logic [RW+1:0] diff;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[DW-2:0], ~diff[RW+1]};
            rem_next = diff[RW+1] ? shifted[RW-1:0] : diff[RW-1:0];
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

/* hdl/mandelbrot_escape_time.sv */
// Mandelbrot escape-time point evaluator, one pixel at a time.
// Runs from start to done through the divider, MAP_X, MAP_Y, MAP_C and the
// iteration states, n iterations run; a zero image width skips the divider.
// A new request is taken only in idle, after done; busy blocks new requests meanwhile.
// Each iteration steps through MUL_XY, MUL_XX, MUL_YY and SQ_Y on the single shared signed multiplier.
// Reset (async, low) restores register defaults and idles; done cannot be stalled.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_defines.svh"

module mandelbrot_escape_time #(
    parameter int INDEX_BITS = 32,
    parameter int FRAC_BITS  = 28,
    parameter int ITER_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [met_pkg::PIXEL_W-1:0]        pixel_index,
    output logic                               done,
    output logic [met_pkg::VALUE_W-1:0]        pixel_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [met_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [met_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int QW   = FRAC_BITS + 8;
    localparam int PW   = 2 * QW;
    localparam int SP_W = met_pkg::SP_W;
    localparam int WW   = (PW > SP_W + 2) ? PW : SP_W + 2;
    localparam int W_W  = met_pkg::WIDTH_W;

    localparam logic signed [QW-1:0] Q_MAX  = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN  = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [WW-1:0] X_BASE = -(WW'(5) << (FRAC_BITS - 1));
    localparam logic signed [WW-1:0] Y_BASE = -(WW'(2) << FRAC_BITS);
    localparam logic [QW:0]          FOUR   = (QW + 1)'(4) << FRAC_BITS;

    function automatic logic signed [QW-1:0] sat_q(input logic signed [WW-1:0] v);
        logic [WW-QW:0] top;
        top = v[WW-1:QW-1];
        if ((&top) || !(|top))
            return v[QW-1:0];
        else if (v[WW-1])
            return Q_MIN;
        else
            return Q_MAX;
    endfunction

    met_pkg::state_t state_reg, state_next;

    logic [W_W-1:0]                  width_reg;
    logic [met_pkg::STEP_W-1:0]      x_step_reg;
    logic [met_pkg::STEP_W-1:0]      y_step_reg;
    logic [met_pkg::LIMIT_W-1:0]     max_iter_reg;

    logic [W_W-1:0]                  col_reg, col_next;
    logic [W_W-1:0]                  row_reg, row_next;
    logic [SP_W-1:0]                 sprod_reg, sprod_next;
    logic signed [QW-1:0]            x0_reg, x0_next;
    logic signed [QW-1:0]            y0_reg, y0_next;
    logic signed [QW-1:0]            x_reg, x_next;
    logic signed [QW-1:0]            y_reg, y_next;
    logic signed [QW-1:0]            x2_reg, x2_next;
    logic signed [QW-1:0]            y2_reg, y2_next;
    logic signed [PW-1:0]            prod_reg, prod_next;
    logic [ITER_BITS-1:0]            count_reg, count_next;

    logic [INDEX_BITS-1:0]           idx;
    logic [W_W-1:0]                  idx_row;
    logic                            div_start;
    met_pkg::div_status_t            div_status;
    logic [INDEX_BITS-1:0]           div_quo;
    logic [W_W-1:0]                  div_rem;
    logic [W_W-1:0]                  quo_row;

    logic signed [QW-1:0]            mul_a, mul_b;
    logic [W_W-1:0]                  smul_a;
    logic [met_pkg::STEP_W-1:0]      smul_b;
    logic signed [WW-1:0]            sprod_ext;
    logic signed [QW-1:0]            x_diff, x_new, xy_q, y_new, sq_q, x0_new, y0_new;
    logic [QW:0]                     mag;
    logic [ITER_BITS-1:0]            count_inc;
    logic [ITER_BITS-1:0]            limit;
    logic                            keep_going;

    assign idx       = INDEX_BITS'(pixel_index);
    assign idx_row   = (idx > INDEX_BITS'(met_pkg::ROW_MAX)) ? met_pkg::ROW_MAX : idx[W_W-1:0];
    assign quo_row   = (div_quo > INDEX_BITS'(met_pkg::ROW_MAX)) ?
                       met_pkg::ROW_MAX : div_quo[W_W-1:0];
    assign div_start = (state_reg == met_pkg::S_IDLE) && start && (width_reg != '0);
    assign limit     = max_iter_reg[ITER_BITS-1:0];

    met_div #(
        .DW (INDEX_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (idx),
        .divisor   (width_reg),
        .status    (div_status),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            met_pkg::S_MUL_XX:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            met_pkg::S_MUL_YY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
        endcase
    end

    assign smul_a     = (state_reg == met_pkg::S_MAP_X) ? col_reg : row_reg;
    assign smul_b     = (state_reg == met_pkg::S_MAP_X) ? x_step_reg : y_step_reg;
    assign sprod_next = SP_W'(smul_a) * SP_W'(smul_b);
    assign prod_next  = PW'(mul_a) * PW'(mul_b);

    assign sprod_ext  = WW'($signed({1'b0, sprod_reg}));
    assign x0_new     = sat_q(X_BASE + sprod_ext);
    assign y0_new     = sat_q(Y_BASE + sprod_ext);
    assign x_diff     = sat_q(WW'(x2_reg) - WW'(y2_reg));
    assign x_new      = sat_q(WW'(x_diff) + WW'(x0_reg));
    assign xy_q       = sat_q(WW'(prod_reg >>> (FRAC_BITS - 1)));
    assign y_new      = sat_q(WW'(xy_q) + WW'(y0_reg));
    assign sq_q       = sat_q(WW'(prod_reg >>> FRAC_BITS));
    assign mag        = {1'b0, x2_reg} + {1'b0, sq_q};
    assign count_inc  = count_reg + 1'b1;
    assign keep_going = (count_inc < limit) && (mag < FOUR);

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        x2_next    = x2_reg;
        y2_next    = y2_reg;
        count_next = count_reg;
        case (state_reg)
            met_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (width_reg == '0)
                    begin
                        col_next   = '0;
                        row_next   = idx_row;
                        state_next = met_pkg::S_MAP_X;
                    end
                    else
                    begin
                        state_next = met_pkg::S_DIV;
                    end
                end
            end
            met_pkg::S_DIV:
            begin
                if (div_status.done)
                begin
                    col_next   = div_rem;
                    row_next   = quo_row;
                    state_next = met_pkg::S_MAP_X;
                end
            end
            met_pkg::S_MAP_X:
            begin
                state_next = met_pkg::S_MAP_Y;
            end
            met_pkg::S_MAP_Y:
            begin
                x0_next    = x0_new;
                state_next = met_pkg::S_MAP_C;
            end
            met_pkg::S_MAP_C:
            begin
                y0_next    = y0_new;
                x_next     = '0;
                y_next     = '0;
                x2_next    = '0;
                y2_next    = '0;
                count_next = '0;
                state_next = (limit == '0) ? met_pkg::S_DONE : met_pkg::S_MUL_XY;
            end
            met_pkg::S_MUL_XY:
            begin
                x_next     = x_new;
                state_next = met_pkg::S_MUL_XX;
            end
            met_pkg::S_MUL_XX:
            begin
                y_next     = y_new;
                state_next = met_pkg::S_MUL_YY;
            end
            met_pkg::S_MUL_YY:
            begin
                x2_next    = sq_q;
                state_next = met_pkg::S_SQ_Y;
            end
            met_pkg::S_SQ_Y:
            begin
                y2_next    = sq_q;
                count_next = count_inc;
                state_next = keep_going ? met_pkg::S_MUL_XY : met_pkg::S_DONE;
            end
            met_pkg::S_DONE:
            begin
                state_next = met_pkg::S_IDLE;
            end
            default:
            begin
                state_next = met_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= met_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        sprod_reg <= sprod_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        prod_reg  <= prod_next;
        count_reg <= count_next;
    end

    // register file write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= met_pkg::RST_IMAGE_WIDTH;
            x_step_reg   <= met_pkg::RST_X_STEP;
            y_step_reg   <= met_pkg::RST_Y_STEP;
            max_iter_reg <= met_pkg::RST_MAX_ITERATIONS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                met_pkg::CFG_IMAGE_WIDTH:    width_reg    <= cfg_data[W_W-1:0];
                met_pkg::CFG_X_STEP:         x_step_reg   <= cfg_data[met_pkg::STEP_W-1:0];
                met_pkg::CFG_Y_STEP:         y_step_reg   <= cfg_data[met_pkg::STEP_W-1:0];
                met_pkg::CFG_MAX_ITERATIONS: max_iter_reg <= cfg_data[met_pkg::LIMIT_W-1:0];
                default:                     width_reg    <= width_reg;
            endcase
        end
    end

    assign cfg_ready   = 1'b1;
    assign busy        = (state_reg != met_pkg::S_IDLE);
    assign done        = (state_reg == met_pkg::S_DONE);
    assign pixel_value = met_pkg::VALUE_W'(limit - count_reg);

    `MET_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request accepted but block not busy")
    `MET_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "done not a single-cycle strobe")
    `MET_ASSERT(a_count_limit, done |-> (count_reg <= limit), "iteration count above limit")
    `MET_ASSERT(a_div_idle, div_status.busy |-> (state_reg == met_pkg::S_DIV), "divider running outside divide state")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for mandelbrot_escape_time: directed table, then random phases.
// Predicts each pixel_value in Q8.28 fixed point and checks every done strobe in order.
// Depends on met_pkg and the mandelbrot_escape_time RTL.
`timescale 1ns / 1ps

module tb_top;

    import met_pkg::*;

    localparam int  FRAC           = 28;
    localparam int  INDEX_LATENCY  = 32 + 5;
    localparam int  END_WAIT       = 4 * INDEX_LATENCY;
    localparam int  WATCHDOG_LIMIT = 1000000;
    localparam int  PHASES         = 12;
    localparam int  PHASE_ITEMS    = 49;
    localparam longint Q_HI        = (longint'(1) <<< (FRAC + 7)) - 1;
    localparam longint Q_LO        = -Q_HI - 1;
    localparam longint ONE_Q       = longint'(1) <<< FRAC;

    localparam logic [CFG_INDEX_W-1:0] CFG_NONE = 4'hF;

    localparam logic ROW_PIXEL = 1'b0;
    localparam logic ROW_REG   = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [31:0]            value;
        logic                   pinned;
        logic [VALUE_W-1:0]     pinned_value;
    } plan_row_t;

    localparam int PLAN_LEN = 27;

    // Row 512, column 640 of the reset geometry is c = 0; column 128 is c = -2.
    plan_row_t plan [0:PLAN_LEN-1] = '{
        '{ROW_PIXEL, CFG_NONE,           32'd0,          1'b1, 16'd999},
        '{ROW_PIXEL, CFG_NONE,           32'd524928,     1'b1, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'd524416,     1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'hFFFF_FFFF,  1'b1, 16'd999},
        '{ROW_REG,   CFG_MAX_ITERATIONS, 32'd0,          1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'd524928,     1'b1, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'h5555_AAAA,  1'b1, 16'd0},
        '{ROW_REG,   CFG_MAX_ITERATIONS, 32'hFFFF_FFFF,  1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'd0,          1'b1, 16'd65534},
        '{ROW_PIXEL, CFG_NONE,           32'd524928,     1'b1, 16'd0},
        '{ROW_REG,   CFG_MAX_ITERATIONS, 32'hABCD_0064,  1'b0, 16'd0},
        '{ROW_REG,   CFG_IMAGE_WIDTH,    32'd0,          1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'd512,        1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'hAAAA_5555,  1'b0, 16'd0},
        '{ROW_REG,   CFG_IMAGE_WIDTH,    32'hFFFF_FFFF,  1'b0, 16'd0},
        '{ROW_REG,   CFG_X_STEP,         32'hFFFF_FFFF,  1'b0, 16'd0},
        '{ROW_REG,   CFG_Y_STEP,         32'd0,          1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'hFFFF_FFFF,  1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'd65534,      1'b0, 16'd0},
        '{ROW_REG,   CFG_X_STEP,         32'h4000_0000,  1'b0, 16'd0},
        '{ROW_REG,   CFG_Y_STEP,         32'h4000_0000,  1'b0, 16'd0},
        '{ROW_REG,   CFG_IMAGE_WIDTH,    32'd1,          1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'd0,          1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'd1,          1'b0, 16'd0},
        '{ROW_REG,   CFG_NONE,           32'hFFFF_FFFF,  1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'd2,          1'b0, 16'd0},
        '{ROW_PIXEL, CFG_NONE,           32'h8000_0001,  1'b0, 16'd0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [PIXEL_W-1:0]     pixel_index = '0;
    logic                   done;
    logic [VALUE_W-1:0]     pixel_value;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_NONE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   pinned_on = 1'b0;
    logic [VALUE_W-1:0]     pinned_value = '0;

    logic [WIDTH_W-1:0]     model_width  = RST_IMAGE_WIDTH;
    logic [STEP_W-1:0]      model_x_step = RST_X_STEP;
    logic [STEP_W-1:0]      model_y_step = RST_Y_STEP;
    logic [LIMIT_W-1:0]     model_limit  = RST_MAX_ITERATIONS;

    logic [VALUE_W-1:0]     pending_values [$];
    int                     error_count = 0;
    int                     idle_cycles = 0;

    mandelbrot_escape_time dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel_index (pixel_index),
        .done        (done),
        .pixel_value (pixel_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp_q(input longint v);
        if (v > Q_HI)
        begin
            return Q_HI;
        end
        if (v < Q_LO)
        begin
            return Q_LO;
        end
        return v;
    endfunction

    function automatic longint fixed_mul(input longint a, input longint b, input int sh);
        logic signed [79:0] wa;
        logic signed [79:0] wb;
        logic signed [79:0] p;
        wa = a;
        wb = b;
        p = (wa * wb) >>> sh;
        if (p > Q_HI)
        begin
            return Q_HI;
        end
        if (p < Q_LO)
        begin
            return Q_LO;
        end
        return longint'(p);
    endfunction

    function automatic logic [VALUE_W-1:0] predict_pixel_value(input logic [PIXEL_W-1:0] idx);
        longint col;
        longint row;
        longint xs;
        longint ys;
        longint x0;
        longint y0;
        longint x;
        longint y;
        longint x2;
        longint y2;
        longint n;
        longint lim;
        xs = model_x_step;
        ys = model_y_step;
        lim = model_limit;
        if (model_width == 0)
        begin
            col = 0;
            row = idx;
        end
        else
        begin
            col = idx % model_width;
            row = idx / model_width;
        end
        if (row > 65535)
        begin
            row = 65535;
        end
        x0 = clamp_q(col * xs - (longint'(5) <<< (FRAC - 1)));
        y0 = clamp_q(row * ys - (longint'(2) <<< FRAC));
        x = 0;
        y = 0;
        x2 = 0;
        y2 = 0;
        n = 0;
        while (n < lim && x2 + y2 < 4 * ONE_Q)
        begin
            y = clamp_q(fixed_mul(x, y, FRAC - 1) + y0);
            x = clamp_q(clamp_q(x2 - y2) + x0);
            x2 = fixed_mul(x, x, FRAC);
            y2 = fixed_mul(y, y, FRAC);
            n++;
        end
        return VALUE_W'(lim - n);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Scoreboard: check results first so a request taken on the same edge stays queued.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_width  = RST_IMAGE_WIDTH;
            model_x_step = RST_X_STEP;
            model_y_step = RST_Y_STEP;
            model_limit  = RST_MAX_ITERATIONS;
            idle_cycles  = 0;
        end
        else
        begin
            idle_cycles++;
            if (done)
            begin
                idle_cycles = 0;
                if (pending_values.size() == 0)
                begin
                    report_mismatch("pixel_value with no request waiting", pixel_value, 0);
                end
                else if (pixel_value !== pending_values[0])
                begin
                    report_mismatch("pixel_value", pixel_value, pending_values.pop_front());
                end
                else
                begin
                    void'(pending_values.pop_front());
                end
            end
            if (start && !busy)
            begin
                idle_cycles = 0;
                if (pinned_on)
                begin
                    pending_values.push_back(pinned_value);
                end
                else
                begin
                    pending_values.push_back(predict_pixel_value(pixel_index));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                idle_cycles = 0;
                case (cfg_index)
                    CFG_IMAGE_WIDTH:    model_width  = cfg_data[WIDTH_W-1:0];
                    CFG_X_STEP:         model_x_step = cfg_data[STEP_W-1:0];
                    CFG_Y_STEP:         model_y_step = cfg_data[STEP_W-1:0];
                    CFG_MAX_ITERATIONS: model_limit  = cfg_data[LIMIT_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] idx, input logic pin,
                              input logic [VALUE_W-1:0] pin_value, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        pixel_index  <= idx;
        pinned_on    <= pin;
        pinned_value <= pin_value;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_values.size() != 0 || busy)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int               cols;
        int               rows;
        int               lim;
        int               draw;
        bit               eager;
        bit               noisy;
        logic [31:0]      idx;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_LEN; r++)
        begin
            if (plan[r].kind == ROW_REG)
            begin
                drain();
                write_reg(plan[r].reg_index, plan[r].value);
            end
            else
            begin
                send_pixel(plan[r].value, plan[r].pinned, plan[r].pinned_value,
                           $urandom_range(0, 6));
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            noisy = (p % 4 == 3);
            eager = ($urandom_range(0, 3) == 0);
            drain();
            if (noisy)
            begin
                draw = $urandom_range(0, 3);
                cols = (draw == 0) ? 0 : (draw == 1) ? 1 :
                       (draw == 2) ? 65535 : $urandom_range(2, 65535);
                rows = 1;
                lim = $urandom_range(1, 60);
                write_reg(CFG_IMAGE_WIDTH, {16'($urandom), 16'(cols)});
                write_reg(CFG_X_STEP, $urandom);
                write_reg(CFG_Y_STEP, $urandom);
            end
            else
            begin
                // Frame the full set: steps of 4/width and 4/height.
                cols = $urandom_range(1, 48);
                rows = $urandom_range(1, 48);
                draw = $urandom_range(0, 9);
                lim = (draw < 7) ? $urandom_range(1, 40) : $urandom_range(41, 250);
                write_reg(CFG_IMAGE_WIDTH, {16'($urandom), 16'(cols)});
                write_reg(CFG_X_STEP, {1'($urandom), 31'((ONE_Q * 4) / cols)});
                write_reg(CFG_Y_STEP, {1'($urandom), 31'((ONE_Q * 4) / rows)});
            end
            write_reg(CFG_MAX_ITERATIONS, {16'($urandom), 16'(lim)});

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (noisy || $urandom_range(0, 7) == 0)
                begin
                    idx = $urandom;
                end
                else
                begin
                    idx = $urandom_range(0, cols * rows - 1);
                end
                send_pixel(idx, 1'b0, '0, eager ? 0 : $urandom_range(0, 6));
            end
        end

        drain();
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/met_pkg.sv
hdl/met_div.sv
hdl/mandelbrot_escape_time.sv
tb/tb_top.sv
